// File: hw/rtl/svst_pkg.sv
// Package: shared types, widths and constants of the SVPWM sector timing pipeline.
`default_nettype none
package svst_pkg;

  // Payload widths
  localparam int unsigned VOLT_W   = 16;
  localparam int unsigned CMP_W    = 16;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned GAIN_W   = 18;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 18;
  localparam logic [CFG_IDX_W-1:0] REG_PWM_PERIOD   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VOLT_TO_TIME = 2'd1;
  localparam logic [PERIOD_W-1:0]  PWM_PERIOD_RST   = 16'd3600;
  localparam logic [GAIN_W-1:0]    VOLT_TO_TIME_RST = 18'd133022;

  // Internal datapath widths
  localparam int unsigned ABC_W  = 34;             // B and C in Q16 volts
  localparam int unsigned PX_W   = 35;             // gain * beta
  localparam int unsigned PYZ_W  = ABC_W + GAIN_W + 1; // gain * (-C) or (-B), Q34
  localparam int unsigned FRAC_SH = 18;            // Q34 -> Q16 counts
  localparam int unsigned T_W    = PYZ_W - FRAC_SH; // Ta / Tb in Q16 counts
  localparam int unsigned V_W    = 37;             // 4*V in Q16, i.e. V in Q18
  localparam int unsigned WHOLE_W = V_W - 1 - FRAC_SH;

  // sqrt(3)/2 in Q16
  localparam logic signed [ABC_W-1:0] SQRT3_HALF_Q16 = 34'sd56756;

  // Sign code: bit0 A>0, bit1 B>0, bit2 C>0
  typedef enum logic [2:0] {
    SEC_NONE = 3'd0,
    SEC_1    = 3'd1,
    SEC_2    = 3'd2,
    SEC_3    = 3'd3,
    SEC_4    = 3'd4,
    SEC_5    = 3'd5,
    SEC_6    = 3'd6,
    SEC_ALL  = 3'd7
  } sector_e;

  typedef struct packed {
    logic signed [VOLT_W-1:0] u_alpha;
    logic signed [VOLT_W-1:0] u_beta;
  } in_t;

  typedef struct packed {
    logic [CMP_W-1:0] compare_a;
    logic [CMP_W-1:0] compare_b;
    logic [CMP_W-1:0] compare_c;
    logic [2:0]       sector_code;
    logic             clamped;
  } out_t;

endpackage
`default_nettype wire

// File: hw/rtl/svst_frontend.sv
// Stage 1: Clarke-style A/B/C projection and sector sign code.
`default_nettype none
module svst_frontend (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   valid_i,
  output logic                                        ready_o,
  input  wire svst_pkg::in_t                          data_i,
  output logic                                        valid_o,
  input  wire logic                                   ready_i,
  output logic signed [svst_pkg::VOLT_W-1:0]          beta_o,
  output logic signed [svst_pkg::ABC_W-1:0]           neg_b_o,
  output logic signed [svst_pkg::ABC_W-1:0]           neg_c_o,
  output svst_pkg::sector_e                           sector_o
);

  logic signed [svst_pkg::ABC_W-1:0] alpha_x;
  logic signed [svst_pkg::ABC_W-1:0] k_alpha;
  logic signed [svst_pkg::ABC_W-1:0] half_beta;
  logic signed [svst_pkg::ABC_W-1:0] neg_b_d, neg_c_d;
  logic signed [svst_pkg::ABC_W-1:0] neg_b_q, neg_c_q;
  logic signed [svst_pkg::VOLT_W-1:0] beta_q;
  svst_pkg::sector_e sector_d, sector_q;
  logic valid_q;
  logic en;

  // Advance when the stage is empty or its content moves on
  assign en      = !valid_q || ready_i;
  assign ready_o = en;

  // Form -B = beta/2 - k*alpha and -C = k*alpha + beta/2 in Q16
  always_comb begin
    alpha_x   = {{(svst_pkg::ABC_W-svst_pkg::VOLT_W){data_i.u_alpha[svst_pkg::VOLT_W-1]}},
                 data_i.u_alpha};
    k_alpha   = alpha_x * svst_pkg::SQRT3_HALF_Q16;
    half_beta = {{(svst_pkg::ABC_W-svst_pkg::VOLT_W-15){data_i.u_beta[svst_pkg::VOLT_W-1]}},
                 data_i.u_beta, 15'b0};
    neg_b_d   = half_beta - k_alpha;
    neg_c_d   = k_alpha + half_beta;
    sector_d  = svst_pkg::sector_e'({neg_c_d[svst_pkg::ABC_W-1],
                                     neg_b_d[svst_pkg::ABC_W-1],
                                     (data_i.u_beta > 0)});
  end

  // Hold valid in step with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= valid_i;
    end
  end

  // Load the payload
  always_ff @(posedge clk_i) begin
    if (en && valid_i) begin
      beta_q   <= data_i.u_beta;
      neg_b_q  <= neg_b_d;
      neg_c_q  <= neg_c_d;
      sector_q <= sector_d;
    end
  end

  assign valid_o  = valid_q;
  assign beta_o   = beta_q;
  assign neg_b_o  = neg_b_q;
  assign neg_c_o  = neg_c_q;
  assign sector_o = sector_q;

endmodule
`default_nettype wire

// File: hw/rtl/svst_gain.sv
// Stages 2 and 3: gain multiplies for X, Y, Z and per-sector Ta/Tb selection.
`default_nettype none
module svst_gain (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic [svst_pkg::GAIN_W-1:0]            gain_i,
  input  wire logic                                   valid_i,
  output logic                                        ready_o,
  input  wire logic signed [svst_pkg::VOLT_W-1:0]     beta_i,
  input  wire logic signed [svst_pkg::ABC_W-1:0]      neg_b_i,
  input  wire logic signed [svst_pkg::ABC_W-1:0]      neg_c_i,
  input  wire svst_pkg::sector_e                      sector_i,
  output logic                                        valid_o,
  input  wire logic                                   ready_i,
  output logic signed [svst_pkg::T_W-1:0]             ta_o,
  output logic signed [svst_pkg::T_W-1:0]             tb_o,
  output svst_pkg::sector_e                           sector_o
);

  logic signed [svst_pkg::PX_W-1:0]  beta_x, gain_px;
  logic signed [svst_pkg::PYZ_W-1:0] nc_x, nb_x, gain_pyz;
  logic signed [svst_pkg::PX_W-1:0]  px_q;
  logic signed [svst_pkg::PYZ_W-1:0] py_q, pz_q;
  logic signed [svst_pkg::PYZ_W-1:0] y_full, z_full;
  logic signed [svst_pkg::T_W-1:0]   x, y, z;
  logic signed [svst_pkg::T_W-1:0]   ta_d, tb_d, ta_q, tb_q;
  svst_pkg::sector_e sec2_q, sec3_q;
  logic valid2_q, valid3_q;
  logic en2, en3;

  assign en3     = !valid3_q || ready_i;
  assign en2     = !valid2_q || en3;
  assign ready_o = en2;

  // Stage 2: multiply by the volt-to-time gain
  always_comb begin
    beta_x   = {{(svst_pkg::PX_W-svst_pkg::VOLT_W){beta_i[svst_pkg::VOLT_W-1]}}, beta_i};
    gain_px  = {{(svst_pkg::PX_W-svst_pkg::GAIN_W){1'b0}}, gain_i};
    nc_x     = {{(svst_pkg::PYZ_W-svst_pkg::ABC_W){neg_c_i[svst_pkg::ABC_W-1]}}, neg_c_i};
    nb_x     = {{(svst_pkg::PYZ_W-svst_pkg::ABC_W){neg_b_i[svst_pkg::ABC_W-1]}}, neg_b_i};
    gain_pyz = {{(svst_pkg::PYZ_W-svst_pkg::GAIN_W){1'b0}}, gain_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid2_q <= 1'b0;
    end else if (en2) begin
      valid2_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2 && valid_i) begin
      px_q   <= beta_x * gain_px;
      py_q   <= nc_x * gain_pyz;
      pz_q   <= nb_x * gain_pyz;
      sec2_q <= sector_i;
    end
  end

  // Stage 3: floor to Q16 counts, then pick Ta and Tb per sector
  always_comb begin
    x      = px_q >>> 2;
    y_full = py_q >>> svst_pkg::FRAC_SH;
    z_full = pz_q >>> svst_pkg::FRAC_SH;
    y      = y_full[svst_pkg::T_W-1:0];
    z      = z_full[svst_pkg::T_W-1:0];
    unique case (sec2_q)
      svst_pkg::SEC_3: begin ta_d = -z; tb_d = x;  end
      svst_pkg::SEC_1: begin ta_d = z;  tb_d = y;  end
      svst_pkg::SEC_5: begin ta_d = x;  tb_d = -y; end
      svst_pkg::SEC_4: begin ta_d = -x; tb_d = z;  end
      svst_pkg::SEC_6: begin ta_d = -y; tb_d = -z; end
      svst_pkg::SEC_2: begin ta_d = y;  tb_d = -x; end
      default:         begin ta_d = '0; tb_d = '0; end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid3_q <= 1'b0;
    end else if (en3) begin
      valid3_q <= valid2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3 && valid2_q) begin
      ta_q   <= ta_d;
      tb_q   <= tb_d;
      sec3_q <= sec2_q;
    end
  end

  assign valid_o  = valid3_q;
  assign ta_o     = ta_q;
  assign tb_o     = tb_q;
  assign sector_o = sec3_q;

endmodule
`default_nettype wire

// File: hw/rtl/svst_compare.sv
// Stages 4 and 5: compare sums, phase routing, clamping and the output register.
`default_nettype none
module svst_compare (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic [svst_pkg::PERIOD_W-1:0]          period_i,
  input  wire logic                                   valid_i,
  output logic                                        ready_o,
  input  wire logic signed [svst_pkg::T_W-1:0]        ta_i,
  input  wire logic signed [svst_pkg::T_W-1:0]        tb_i,
  input  wire svst_pkg::sector_e                      sector_i,
  output logic                                        valid_o,
  input  wire logic                                   ready_i,
  output svst_pkg::out_t                              data_o
);

  logic signed [svst_pkg::V_W-1:0] p_x, ta_x, tb_x;
  logic signed [svst_pkg::V_W-1:0] v1, v2, v3;
  logic signed [svst_pkg::V_W-1:0] r_d [3];
  logic signed [svst_pkg::V_W-1:0] r_q [3];
  logic [svst_pkg::CMP_W-1:0]      cmp_d [3];
  logic [2:0]                      sat;
  logic [svst_pkg::WHOLE_W-1:0]    whole [3];
  logic [svst_pkg::WHOLE_W-1:0]    period_x;
  svst_pkg::sector_e sec4_q;
  svst_pkg::out_t out_d, out_q;
  logic valid4_q, valid5_q;
  logic en4, en5;

  assign en5     = !valid5_q || ready_i;
  assign en4     = !valid4_q || en5;
  assign ready_o = en4;

  // Stage 4: form 4*V1..4*V3 side by side and route them to the phases
  always_comb begin
    p_x  = {{(svst_pkg::V_W-svst_pkg::PERIOD_W-16){1'b0}}, period_i, 16'b0};
    ta_x = {{(svst_pkg::V_W-svst_pkg::T_W){ta_i[svst_pkg::T_W-1]}}, ta_i};
    tb_x = {{(svst_pkg::V_W-svst_pkg::T_W){tb_i[svst_pkg::T_W-1]}}, tb_i};
    v1   = p_x - ta_x - tb_x;
    v2   = p_x + ta_x - tb_x;
    v3   = p_x + ta_x + tb_x;
    unique case (sector_i)
      svst_pkg::SEC_3: begin r_d[0] = v1; r_d[1] = v2; r_d[2] = v3; end
      svst_pkg::SEC_1: begin r_d[0] = v2; r_d[1] = v1; r_d[2] = v3; end
      svst_pkg::SEC_5: begin r_d[0] = v3; r_d[1] = v1; r_d[2] = v2; end
      svst_pkg::SEC_4: begin r_d[0] = v3; r_d[1] = v2; r_d[2] = v1; end
      svst_pkg::SEC_6: begin r_d[0] = v2; r_d[1] = v3; r_d[2] = v1; end
      svst_pkg::SEC_2: begin r_d[0] = v1; r_d[1] = v3; r_d[2] = v2; end
      default:         begin r_d[0] = '0; r_d[1] = '0; r_d[2] = '0; end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid4_q <= 1'b0;
    end else if (en4) begin
      valid4_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4 && valid_i) begin
      r_q    <= r_d;
      sec4_q <= sector_i;
    end
  end

  // Stage 5: drop the fraction and saturate to 0..period
  always_comb begin
    period_x = {{(svst_pkg::WHOLE_W-svst_pkg::PERIOD_W){1'b0}}, period_i};
    for (int k = 0; k < 3; k++) begin
      whole[k] = r_q[k][svst_pkg::V_W-2:svst_pkg::FRAC_SH];
      if (r_q[k][svst_pkg::V_W-1]) begin
        cmp_d[k] = '0;
        sat[k]   = 1'b1;
      end else if (whole[k] > period_x) begin
        cmp_d[k] = period_i;
        sat[k]   = 1'b1;
      end else begin
        cmp_d[k] = whole[k][svst_pkg::CMP_W-1:0];
        sat[k]   = 1'b0;
      end
    end
    out_d.compare_a   = cmp_d[0];
    out_d.compare_b   = cmp_d[1];
    out_d.compare_c   = cmp_d[2];
    out_d.sector_code = sec4_q;
    out_d.clamped     = |sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid5_q <= 1'b0;
    end else if (en5) begin
      valid5_q <= valid4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en5 && valid4_q) begin
      out_q <= out_d;
    end
  end

  assign valid_o = valid5_q;
  assign data_o  = out_q;

endmodule
`default_nettype wire

// File: hw/rtl/svpwm_sector_timing.sv
// Top level: seven-segment SVPWM sector timing pipeline with configuration registers.
//
//   Channel   Direction  Handshake              Payload
//   in        input      in_valid_i/in_ready_o  in_data_i  (u_alpha, u_beta)
//   out       output     out_valid_o/out_ready_i out_data_o (compares, sector, clamped)
//   cfg       input      cfg_we_i               cfg_idx_i, cfg_data_i
//
// Five register stages: projection, gain multiply, Ta/Tb select, compare sums,
// clamp into the output register. One vector per cycle while the output is not stalled.
// The gain multiply stage (18 x 34 bit) sets the clock limit.
// Reset clears the valid bits and loads the register defaults.
// A stall at the output holds each full stage with no empty stage ahead; other stages still move.
`default_nettype none
module svpwm_sector_timing (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [svst_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [svst_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire svst_pkg::in_t                       in_data_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output svst_pkg::out_t                           out_data_o
);

  logic [svst_pkg::PERIOD_W-1:0] period_q;
  logic [svst_pkg::GAIN_W-1:0]   gain_q;

  logic                               fe_valid, fe_ready;
  logic signed [svst_pkg::VOLT_W-1:0] fe_beta;
  logic signed [svst_pkg::ABC_W-1:0]  fe_neg_b, fe_neg_c;
  svst_pkg::sector_e                  fe_sector;

  logic                               gn_valid, gn_ready;
  logic signed [svst_pkg::T_W-1:0]    gn_ta, gn_tb;
  svst_pkg::sector_e                  gn_sector;

  // Write configuration registers; ignore unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= svst_pkg::PWM_PERIOD_RST;
      gain_q   <= svst_pkg::VOLT_TO_TIME_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        svst_pkg::REG_PWM_PERIOD:   period_q <= cfg_data_i[svst_pkg::PERIOD_W-1:0];
        svst_pkg::REG_VOLT_TO_TIME: gain_q   <= cfg_data_i[svst_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  svst_frontend u_frontend (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_valid_i),
    .ready_o  (in_ready_o),
    .data_i   (in_data_i),
    .valid_o  (fe_valid),
    .ready_i  (fe_ready),
    .beta_o   (fe_beta),
    .neg_b_o  (fe_neg_b),
    .neg_c_o  (fe_neg_c),
    .sector_o (fe_sector)
  );

  svst_gain u_gain (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .gain_i   (gain_q),
    .valid_i  (fe_valid),
    .ready_o  (fe_ready),
    .beta_i   (fe_beta),
    .neg_b_i  (fe_neg_b),
    .neg_c_i  (fe_neg_c),
    .sector_i (fe_sector),
    .valid_o  (gn_valid),
    .ready_i  (gn_ready),
    .ta_o     (gn_ta),
    .tb_o     (gn_tb),
    .sector_o (gn_sector)
  );

  svst_compare u_compare (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .period_i (period_q),
    .valid_i  (gn_valid),
    .ready_o  (gn_ready),
    .ta_i     (gn_ta),
    .tb_i     (gn_tb),
    .sector_i (gn_sector),
    .valid_o  (out_valid_o),
    .ready_i  (out_ready_i),
    .data_o   (out_data_o)
  );

  // The input can only back up when the output transaction is stalled
  a_backpressure_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without an output stall");

  // A+B+C is zero, so all three signs positive never reaches the output
  a_no_all_positive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.sector_code != svst_pkg::SEC_ALL))
    else $error("sector code seven at output");

  // The zero vector yields all-zero compares without saturation
  a_zero_vector: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.sector_code == svst_pkg::SEC_NONE)) |->
      (out_data_o.compare_a == '0 && out_data_o.compare_b == '0 &&
       out_data_o.compare_c == '0 && !out_data_o.clamped))
    else $error("zero vector produced nonzero compares");

endmodule
`default_nettype wire
